// File: design/ppp_pkg.sv
// Shared widths, saturation constants and lane flag type for the point projection block.
package ppp_pkg;

  // Coefficient and coordinate width.
  localparam int CW = 32;
  // Configuration data width.
  localparam int PW = 64;
  // Width of an exact homogeneous sum: three 64-bit products plus a shifted offset.
  localparam int HW = 66;
  // Width of the magnitude of a homogeneous sum.
  localparam int MW = 66;
  // Quotient width.
  localparam int QW = 32;
  // Partial remainder width, large enough for the divisor shifted by the quotient width.
  localparam int RW = MW + QW;

  // Saturation values of a 32-bit signed coordinate.
  localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [2:0] REG_P_ROW0_A = 3'd0;
  localparam logic [2:0] REG_P_ROW0_B = 3'd1;
  localparam logic [2:0] REG_P_ROW1_A = 3'd2;
  localparam logic [2:0] REG_P_ROW1_B = 3'd3;
  localparam logic [2:0] REG_P_ROW2_A = 3'd4;
  localparam logic [2:0] REG_P_ROW2_B = 3'd5;
  localparam logic [2:0] REG_P_LAST   = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;
  localparam logic [2:0] REG_WIDTH    = 3'd7;

  // Per-lane sideband that travels with a quotient through the divider.
  typedef struct packed {
    logic dzero;  // divisor is zero
    logic nneg;   // numerator is negative
    logic nzero;  // numerator is zero
    logic qneg;   // quotient is negative
    logic ovf;    // quotient is known to need more than 32 bits
  } lane_flags_t;

endpackage

// File: design/pinhole_point_projection.sv
// Top level of the pinhole point projection pipeline.
// Stages from an accepted request to its result: 2 multiply/sum, 1 prepare, 32 divider
// steps, 1 output register; throughput one point per cycle while the result is not stalled.
// The two 32-step restoring dividers (row and column) set the depth.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset empties the pipeline, clears the matrix to zero and sets both bounds to one.
module pinhole_point_projection #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [ppp_pkg::PW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ppp_pkg::CW-1:0] world_x_i,
  input  logic signed [ppp_pkg::CW-1:0] world_y_i,
  input  logic signed [ppp_pkg::CW-1:0] world_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ppp_pkg::QW-1:0] image_row_o,
  output logic signed [ppp_pkg::QW-1:0] image_col_o,
  output logic                          inside_image_o,
  output logic                          projection_invalid_o
);
  import ppp_pkg::*;

  localparam int NSTG = 3 + QW + 1;

  logic [PW-1:0]        p_q [6];
  logic [15:0]          img_h_q;
  logic [15:0]          img_w_q;
  logic [11:0][CW-1:0]  coef;
  logic                 en;
  logic [NSTG-1:0]      vld_q;
  logic [2:0][HW-1:0]   h;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        p_q[k] <= '0;
      end
      img_h_q <= 16'd1;
      img_w_q <= 16'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= REG_P_LAST) begin
        p_q[cfg_idx_i] <= cfg_data_i;
      end else if (cfg_idx_i == REG_HEIGHT) begin
        img_h_q <= cfg_data_i[15:0];
      end else if (cfg_idx_i == REG_WIDTH) begin
        img_w_q <= cfg_data_i[15:0];
      end
    end
  end

  // Unpack two coefficients per register.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      coef[2*k]   = p_q[k][CW-1:0];
      coef[2*k+1] = p_q[k][PW-1:CW];
    end
  end

  // Global advance: the pipeline moves whenever the output slot is free or taken.
  assign en         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  ppp_homog #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_homog (
    .clk_i    (clk_i),
    .en_i     (en),
    .coef_i   (coef),
    .world_x_i(world_x_i),
    .world_y_i(world_y_i),
    .world_z_i(world_z_i),
    .h_o      (h)
  );

  function automatic logic [MW-1:0] mag(input logic [HW-1:0] v);
    mag = v[HW-1] ? MW'(-v) : MW'(v);
  endfunction

  logic [RW-1:0]  rem_c [2][QW+1];
  logic [MW-1:0]  den_c [2][QW+1];
  logic [QW-1:0]  quo_c [2][QW+1];
  lane_flags_t    flg_c [2][QW+1];
  logic [RW-1:0]  num_sh [2];
  logic [RW-1:0]  den_sh;
  lane_flags_t    flg_d  [2];

  // Prepare stage: magnitudes, signs, zero tests and a quotient overflow test.
  always_comb begin
    den_sh = RW'(mag(h[2])) << QW;
    for (int l = 0; l < 2; l++) begin
      num_sh[l]      = RW'(mag(h[l])) << OUT_FRAC_BITS;
      flg_d[l].dzero = (h[2] == '0);
      flg_d[l].nneg  = h[l][HW-1];
      flg_d[l].nzero = (h[l] == '0);
      flg_d[l].qneg  = h[l][HW-1] ^ h[2][HW-1];
      flg_d[l].ovf   = (num_sh[l] >= den_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem_c[l][0] <= num_sh[l];
        den_c[l][0] <= mag(h[2]);
        quo_c[l][0] <= '0;
        flg_c[l][0] <= flg_d[l];
      end
    end
  end

  // Two divider lanes, one quotient bit per stage, most significant first.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < QW; s++) begin : g_step
      ppp_div_step #(
        .SHIFT(QW - 1 - s)
      ) u_step (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (rem_c[l][s]),
        .den_i  (den_c[l][s]),
        .quo_i  (quo_c[l][s]),
        .flags_i(flg_c[l][s]),
        .rem_o  (rem_c[l][s+1]),
        .den_o  (den_c[l][s+1]),
        .quo_o  (quo_c[l][s+1]),
        .flags_o(flg_c[l][s+1])
      );
    end
  end

  logic [QW-1:0] val [2];
  logic          bad [2];
  logic [QW-1:0] lim [2];
  logic [QW:0]   top_h;
  logic [QW:0]   top_w;
  logic          in_row;
  logic          in_col;

  // Sign, saturation and zero-divisor handling per lane, then the image bound tests.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l] = flg_c[l][QW].qneg ? SAT_NEG : SAT_POS;
      if (flg_c[l][QW].dzero) begin
        bad[l] = 1'b1;
        if (flg_c[l][QW].nzero) begin
          val[l] = '0;
        end else begin
          val[l] = flg_c[l][QW].nneg ? SAT_NEG : SAT_POS;
        end
      end else if (flg_c[l][QW].ovf || (quo_c[l][QW] > lim[l])) begin
        bad[l] = 1'b1;
        val[l] = lim[l];
      end else begin
        bad[l] = 1'b0;
        val[l] = flg_c[l][QW].qneg ? -quo_c[l][QW] : quo_c[l][QW];
      end
    end
    top_h  = (QW+1)'(img_h_q) << OUT_FRAC_BITS;
    top_w  = (QW+1)'(img_w_q) << OUT_FRAC_BITS;
    in_row = !val[0][QW-1] && (val[0] != '0) && ({1'b0, val[0]} < top_h);
    in_col = !val[1][QW-1] && (val[1] != '0) && ({1'b0, val[1]} < top_w);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      image_row_o          <= val[0];
      image_col_o          <= val[1];
      projection_invalid_o <= bad[0] || bad[1];
      inside_image_o       <= !(bad[0] || bad[1]) && in_row && in_col;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];

endmodule

// File: design/ppp_homog.sv
// Two-stage homogeneous product: nine multiplies, then three four-term sums.
module ppp_homog #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [11:0][ppp_pkg::CW-1:0]         coef_i,
  input  logic signed [ppp_pkg::CW-1:0]        world_x_i,
  input  logic signed [ppp_pkg::CW-1:0]        world_y_i,
  input  logic signed [ppp_pkg::CW-1:0]        world_z_i,
  output logic [2:0][ppp_pkg::HW-1:0]          h_o
);
  import ppp_pkg::*;

  logic signed [2*CW-1:0] prod_q [3][3];
  logic signed [HW-1:0]   off_q  [3];
  logic signed [HW-1:0]   h_q    [3];

  // Stage one: one multiplier per matrix term, offset column scaled to coordinate units.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= $signed(coef_i[4*r])   * world_x_i;
        prod_q[r][1] <= $signed(coef_i[4*r+1]) * world_y_i;
        prod_q[r][2] <= $signed(coef_i[4*r+2]) * world_z_i;
        off_q[r]     <= HW'($signed(coef_i[4*r+3])) <<< COORD_FRAC_BITS;
      end
    end
  end

  // Stage two: exact sums of each row.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        h_q[r] <= HW'(prod_q[r][0]) + HW'(prod_q[r][1]) + HW'(prod_q[r][2]) + off_q[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h_o[r] = h_q[r];
    end
  end

endmodule

// File: design/ppp_div_step.sv
// One restoring division step that resolves a single quotient bit.
module ppp_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ppp_pkg::RW-1:0]       rem_i,
  input  logic [ppp_pkg::MW-1:0]       den_i,
  input  logic [ppp_pkg::QW-1:0]       quo_i,
  input  ppp_pkg::lane_flags_t         flags_i,
  output logic [ppp_pkg::RW-1:0]       rem_o,
  output logic [ppp_pkg::MW-1:0]       den_o,
  output logic [ppp_pkg::QW-1:0]       quo_o,
  output ppp_pkg::lane_flags_t         flags_o
);
  import ppp_pkg::*;

  localparam int RW1 = RW + 1;

  logic [RW:0]    dsh;
  logic [RW:0]    diff;
  logic           take;
  logic [QW-1:0]  quo_d;
  logic [RW-1:0]  rem_d;

  // Trial subtraction of the shifted divisor; no borrow means the bit is one.
  always_comb begin
    dsh          = RW1'(den_i) << SHIFT;
    diff         = {1'b0, rem_i} - dsh;
    take         = !diff[RW];
    rem_d        = take ? diff[RW-1:0] : rem_i;
    quo_d        = quo_i;
    quo_d[SHIFT] = take;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o   <= rem_d;
      den_o   <= den_i;
      quo_o   <= quo_d;
      flags_o <= flags_i;
    end
  end

endmodule

// File: design/ppp_checker.sv
// Port-level checks for the point projection block and their binding.
module ppp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] image_row_o,
  input logic [31:0] image_col_o,
  input logic        inside_image_o,
  input logic        projection_invalid_o
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input side is ready exactly when the output slot can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output slot");

  // An invalid projection is never reported inside the image.
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && projection_invalid_o |-> !inside_image_o)
    else $error("invalid projection marked inside");

  // An invalid projection carries a clamped or zero coordinate.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && projection_invalid_o |->
      image_row_o == 32'h7FFF_FFFF || image_row_o == 32'h8000_0000 ||
      image_row_o == 32'h0 || image_col_o == 32'h7FFF_FFFF ||
      image_col_o == 32'h8000_0000 || image_col_o == 32'h0)
    else $error("invalid projection without a clamped coordinate");

  // Leaving reset, no result is pending.
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending after reset");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);

// File: verif/tb_pinhole_point_projection.sv
// Self-checking testbench for the pinhole point projection block.
`timescale 1ns / 1ps

module tb_pinhole_point_projection;
  import ppp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DEPTH  = 36;

  // One projected point as the block returns it.
  typedef struct {
    logic [QW-1:0] row;
    logic [QW-1:0] col;
    logic          in_img;
    logic          invalid;
  } proj_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i;
  logic [2:0]      cfg_idx_i;
  logic [PW-1:0]   cfg_data_i;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [CW-1:0]   world_x_i, world_y_i, world_z_i;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [QW-1:0]   image_row_o, image_col_o;
  logic            inside_image_o, projection_invalid_o;

  // Predictor copy of the configuration.
  logic [PW-1:0]   p_mat[6];
  logic [15:0]     bound_rows, bound_cols;

  proj_t           pending_proj[$];
  bit              allow_idle = 1'b1;
  int unsigned     n_mismatch = 0;
  int unsigned     n_checked = 0;
  int unsigned     n_invalid = 0;
  int unsigned     n_inside = 0;
  int unsigned     n_cycles = 0;
  int unsigned     rdy_hold = 0;

  pinhole_point_projection uut (.*);

  // Clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [127:0] coef_w(int idx);
    logic [PW-1:0] r;
    r = p_mat[idx / 2];
    return (idx % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
  endfunction

  // Exact homogeneous sum of one matrix row.
  function automatic logic signed [127:0] homog_sum(int r, logic [CW-1:0] x, y, z);
    logic signed [127:0] xw, yw, zw;
    xw = 128'(signed'(x));
    yw = 128'(signed'(y));
    zw = 128'(signed'(z));
    return coef_w(r * 4) * xw + coef_w(r * 4 + 1) * yw + coef_w(r * 4 + 2) * zw
           + (coef_w(r * 4 + 3) <<< 16);
  endfunction

  // Truncating divide with saturation and a zero-divisor rule.
  function automatic logic [QW-1:0] sat_quotient(logic signed [127:0] num, den,
                                                 inout logic bad);
    logic [127:0] n, d, q;
    logic         neg;
    logic [QW-1:0] lim;
    if (den == 0) begin
      bad = 1'b1;
      if (num == 0) return '0;
      return (num < 0) ? SAT_NEG : SAT_POS;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    n = n << 8;
    d = (den < 0) ? -den : den;
    q = n / d;
    lim = neg ? SAT_NEG : SAT_POS;
    if (q > {96'b0, lim}) begin
      bad = 1'b1;
      return lim;
    end
    return neg ? -q[QW-1:0] : q[QW-1:0];
  endfunction

  function automatic logic in_bound(logic [QW-1:0] v, logic [15:0] b);
    logic signed [63:0] vs, top;
    vs = 64'(signed'(v));
    top = 64'(b) * 256;
    return vs > 0 && vs < top;
  endfunction

  function automatic proj_t project_point(logic [CW-1:0] x, y, z);
    proj_t p;
    logic bad;
    bad = 1'b0;
    p.row = sat_quotient(homog_sum(0, x, y, z), homog_sum(2, x, y, z), bad);
    p.col = sat_quotient(homog_sum(1, x, y, z), homog_sum(2, x, y, z), bad);
    p.invalid = bad;
    p.in_img = !bad && in_bound(p.row, bound_rows) && in_bound(p.col, bound_cols);
    return p;
  endfunction

  // Register write followed by an idle wait; the block must be idle.
  task automatic write_reg(logic [2:0] idx, logic [PW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx <= REG_P_LAST) p_mat[idx] = data;
    else if (idx == REG_HEIGHT) bound_rows = data[15:0];
    else bound_cols = data[15:0];
    @(posedge clk_i);
  endtask

  // Wait until every expected result is back, plus pipeline margin.
  task automatic drain();
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // Send one point request, with an optional random gap beforehand.
  task automatic send_point(logic [CW-1:0] x, y, z);
    int gap;
    gap = (allow_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    world_x_i  <= x;
    world_y_i  <= y;
    world_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    pending_proj.push_back(project_point(x, y, z));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Camera matrix with focal length f and principal point (cx, cy), depth on row 2.
  task automatic load_camera(int f, int cx, int cy);
    write_reg(REG_P_ROW0_A, {32'd0, 32'(f <<< 12)});
    write_reg(REG_P_ROW0_B, {32'd0, 32'(cx <<< 12)});
    write_reg(REG_P_ROW1_A, {32'(f <<< 12), 32'd0});
    write_reg(REG_P_ROW1_B, {32'd0, 32'(cy <<< 12)});
    write_reg(REG_P_ROW2_A, 64'd0);
    write_reg(REG_P_ROW2_B, {32'd0, 32'(1 <<< 12)});
  endtask

  // Point within the view cone, in front of the camera for about nine in ten.
  task automatic send_scene_point();
    int z, x, y;
    z = $urandom_range(1 << 14, 60 << 16);
    x = $signed($urandom_range(0, 2 * z)) - z;
    y = $signed($urandom_range(0, 2 * z)) - z;
    if ($urandom_range(0, 9) == 0) z = -z;
    send_point(x, y, z);
  endtask

  task automatic test_reset_defaults();
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point('0, '0, '0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    end_burst();
    drain();
  endtask

  task automatic test_directed_extremes();
    logic [CW-1:0] ext[4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    load_camera(500, 320, 240);
    write_reg(REG_HEIGHT, {$urandom, 32'(480)});
    write_reg(REG_WIDTH, {$urandom, 32'(640)});
    // Optical axis, two off-axis points, behind the camera, and field extremes.
    send_point('0, '0, 32'h0001_0000);
    send_point(32'hFFFF_6000, 32'hFFFF_8800, 32'h0001_0000);
    send_point(32'h0000_A000, 32'h0000_7800, 32'h0001_0000);
    send_point(32'h0000_1000, 32'h0000_1000, 32'hFFFF_0000);
    for (int i = 0; i < 4; i++) send_point(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    // Zero depth with positive and negative numerators.
    send_point(32'h0001_0000, 32'h0001_0000, '0);
    send_point(32'hFFFF_0000, 32'hFFFF_0000, '0);
    end_burst();
    drain();
    // Extreme coefficients and bounds; identical rows make each quotient one.
    for (int i = 0; i <= REG_P_LAST; i++) write_reg(3'(i), {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_HEIGHT, 64'hFFFF);
    write_reg(REG_WIDTH, 64'h1);
    for (int i = 0; i < 4; i++) send_point(ext[i], ext[3 - i], ext[(i + 1) % 4]);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    end_burst();
    drain();
  endtask

  task automatic test_scene_points();
    for (int k = 0; k < 3; k++) begin
      load_camera($urandom_range(50, 2000), $urandom_range(0, 2000),
                  $urandom_range(0, 2000));
      write_reg(REG_HEIGHT, 64'($urandom_range(1, 4000)));
      write_reg(REG_WIDTH, 64'($urandom_range(1, 4000)));
      repeat (250) send_scene_point();
      end_burst();
      drain();
    end
  endtask

  task automatic test_random_matrix();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i <= REG_P_LAST; i++) write_reg(3'(i), {$urandom, $urandom});
      write_reg(REG_HEIGHT, {$urandom, $urandom});
      write_reg(REG_WIDTH, {$urandom, $urandom});
      repeat (120) send_point($urandom, $urandom, $urandom);
      end_burst();
      drain();
    end
  endtask

  task automatic test_zero_divisor();
    load_camera(300, 100, 100);
    write_reg(REG_P_ROW2_A, 64'd0);
    write_reg(REG_P_ROW2_B, 64'd0);
    repeat (60) send_point($urandom, $urandom, $urandom);
    send_point('0, '0, '0);
    end_burst();
    drain();
  endtask

  task automatic test_pause_until_empty();
    load_camera(800, 640, 360);
    write_reg(REG_HEIGHT, 64'd720);
    write_reg(REG_WIDTH, 64'd1280);
    repeat (40) send_scene_point();
    end_burst();
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (40) send_scene_point();
    end_burst();
    drain();
  endtask

  task automatic test_back_to_back();
    allow_idle = 1'b0;
    repeat (300) send_scene_point();
    end_burst();
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_proj.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("Unexpected result row=%h col=%h", image_row_o, image_col_o);
      end else begin
        proj_t e;
        e = pending_proj.pop_front();
        n_checked++;
        n_invalid += e.invalid;
        n_inside += e.in_img;
        if (e.row !== image_row_o || e.col !== image_col_o || e.in_img !== inside_image_o
            || e.invalid !== projection_invalid_o) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"Mismatch: expected row=%h col=%h in=%b inv=%b, ",
                      "got row=%h col=%h in=%b inv=%b"},
                     e.row, e.col, e.in_img, e.invalid, image_row_o, image_col_o,
                     inside_image_o, projection_invalid_o);
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
      out_ready_i <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      rdy_hold <= $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending_proj.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    world_x_i  <= '0;
    world_y_i  <= '0;
    world_z_i  <= '0;
    for (int i = 0; i < 6; i++) p_mat[i] = '0;
    bound_rows = 16'd1;
    bound_cols = 16'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_scene_points();
    test_random_matrix();
    test_zero_divisor();
    test_pause_until_empty();
    test_back_to_back();
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    $display("Checked %0d projected points: %0d inside the image, %0d flagged invalid.",
             n_checked, n_inside, n_invalid);
    $display("Covered default, camera-like, random, extreme and zero-depth matrices.");
    if (n_mismatch == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d", n_mismatch);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/ppp_pkg.sv
design/ppp_homog.sv
design/ppp_div_step.sv
design/pinhole_point_projection.sv
design/ppp_checker.sv
verif/tb_pinhole_point_projection.sv
